FILE: rtl/core/lrb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load reservation buffer package
// Shared widths, command and operation codes, register indexes and the
// result record used by the load reservation buffer modules.
// ----------------------------------------------------------------------------
package lrb_pkg;

	localparam int ENTRIES_DEF   = 4;
	localparam int TAG_BITS_DEF  = 4;
	localparam int DATA_BITS_DEF = 32;

	localparam int CMD_W      = 2;
	localparam int ARRIVAL_W  = 16;
	localparam int LAT_W      = 4;
	localparam int UNITS_W    = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam int ENTRY_W    = 2;
	localparam int ADDR_W     = 32;
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_ISSUE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_BCAST = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_LOAD_LATENCY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOAD_UNITS   = 1'd1;

	localparam logic [LAT_W-1:0]   LATENCY_RST = 4'd2;
	localparam logic [UNITS_W-1:0] UNITS_RST   = 3'd2;
	localparam logic [UNITS_W-1:0] MAX_UNITS   = 3'd4;

	localparam logic KIND_ISSUE = 1'b0;
	localparam logic KIND_DONE  = 1'b1;

	typedef enum logic [1:0] {
		OP_ISSUE = 2'd0,
		OP_BCAST = 2'd1,
		OP_TICK  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EMIT  = 3'b010,
		S_START = 3'b100
	} bstate_t;

	typedef struct packed {
		logic               kind;
		logic               accepted;
		logic [ENTRY_W-1:0] entry;
		logic [ADDR_W-1:0]  address;
		logic               last;
	} res_t;

endpackage

FILE: rtl/core/lrb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load reservation buffer front end
// Accepts input requests, classifies them into issue, broadcast and tick
// operations, drops unknown commands and queues the rest for the back end.
// ----------------------------------------------------------------------------
module lrb_front #(
	parameter int TAG_BITS  = lrb_pkg::TAG_BITS_DEF,
	parameter int DATA_BITS = lrb_pkg::DATA_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [lrb_pkg::CMD_W-1:0]      cmd,
	input  logic [TAG_BITS-1:0]            base_tag,
	input  logic [DATA_BITS-1:0]           base_value,
	input  logic [TAG_BITS-1:0]            offset_tag,
	input  logic [DATA_BITS-1:0]           offset_value,
	input  logic [lrb_pkg::ARRIVAL_W-1:0]  arrival,
	input  logic [TAG_BITS-1:0]            bus_tag,
	input  logic [DATA_BITS-1:0]           bus_value,
	output logic                           cq_valid,
	input  logic                           cq_pop,
	output lrb_pkg::op_t                   cq_op,
	output logic [TAG_BITS-1:0]            cq_tag_a,
	output logic [DATA_BITS-1:0]           cq_val_a,
	output logic [TAG_BITS-1:0]            cq_tag_b,
	output logic [DATA_BITS-1:0]           cq_val_b,
	output logic [lrb_pkg::ARRIVAL_W-1:0]  cq_arrival
);
	import lrb_pkg::*;

	op_t                  op_q  [Q_DEPTH];
	logic [TAG_BITS-1:0]  ta_q  [Q_DEPTH];
	logic [DATA_BITS-1:0] va_q  [Q_DEPTH];
	logic [TAG_BITS-1:0]  tb_q  [Q_DEPTH];
	logic [DATA_BITS-1:0] vb_q  [Q_DEPTH];
	logic [ARRIVAL_W-1:0] ar_q  [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_q;
	logic [Q_PTR_W-1:0]   rd_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	logic                 known;
	logic                 enq;
	logic                 deq;
	op_t                  op_d;
	logic [TAG_BITS-1:0]  ta_d;
	logic [DATA_BITS-1:0] va_d;
	logic [TAG_BITS-1:0]  tb_d;
	logic [DATA_BITS-1:0] vb_d;

	always_comb begin
		known = 1'b1;
		op_d  = OP_ISSUE;
		ta_d  = base_tag;
		va_d  = base_value;
		tb_d  = offset_tag;
		vb_d  = offset_value;
		case (cmd)
			CMD_ISSUE: begin
				op_d = OP_ISSUE;
			end
			CMD_BCAST: begin
				op_d = OP_BCAST;
				ta_d = bus_tag;
				va_d = bus_value;
			end
			CMD_TICK: begin
				op_d = OP_TICK;
			end
			default: begin
				known = 1'b0;
			end
		endcase
	end

	assign full       = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign enq        = push && !full && known;
	assign cq_valid   = (cnt_q != '0);
	assign deq        = cq_pop && cq_valid;
	assign cq_op      = op_q[rd_q];
	assign cq_tag_a   = ta_q[rd_q];
	assign cq_val_a   = va_q[rd_q];
	assign cq_tag_b   = tb_q[rd_q];
	assign cq_val_b   = vb_q[rd_q];
	assign cq_arrival = ar_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			op_q[wr_q] <= op_d;
			ta_q[wr_q] <= ta_d;
			va_q[wr_q] <= va_d;
			tb_q[wr_q] <= tb_d;
			vb_q[wr_q] <= vb_d;
			ar_q[wr_q] <= arrival;
		end
	end

endmodule

FILE: rtl/core/lrb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load reservation buffer back end
// Holds the entry table and the configuration registers, and carries out
// issue, broadcast and tick operations, one result per cycle while res_ready.
// ----------------------------------------------------------------------------
module lrb_back #(
	parameter int ENTRIES   = lrb_pkg::ENTRIES_DEF,
	parameter int TAG_BITS  = lrb_pkg::TAG_BITS_DEF,
	parameter int DATA_BITS = lrb_pkg::DATA_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [lrb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lrb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            cq_valid,
	output logic                            cq_pop,
	input  lrb_pkg::op_t                    cq_op,
	input  logic [TAG_BITS-1:0]             cq_tag_a,
	input  logic [DATA_BITS-1:0]            cq_val_a,
	input  logic [TAG_BITS-1:0]             cq_tag_b,
	input  logic [DATA_BITS-1:0]            cq_val_b,
	input  logic [lrb_pkg::ARRIVAL_W-1:0]   cq_arrival,
	output logic                            res_push,
	input  logic                            res_ready,
	output lrb_pkg::res_t                   res
);
	import lrb_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int SUM_W = IDX_W + 1;

	bstate_t              state_q;
	logic [ENTRIES-1:0]   busy_q;
	logic [ENTRIES-1:0]   run_q;
	logic [ENTRIES-1:0]   cmask_q;
	logic [TAG_BITS-1:0]  btag_q [ENTRIES];
	logic [TAG_BITS-1:0]  otag_q [ENTRIES];
	logic [DATA_BITS-1:0] bval_q [ENTRIES];
	logic [DATA_BITS-1:0] oval_q [ENTRIES];
	logic [LAT_W-1:0]     tick_q [ENTRIES];
	logic [ARRIVAL_W-1:0] arr_q  [ENTRIES];
	logic [IDX_W-1:0]     ptr_q;
	logic [LAT_W-1:0]     lat_q;
	logic [UNITS_W-1:0]   units_q;

	logic                 free_found;
	logic [IDX_W-1:0]     free_idx;
	logic                 best_found;
	logic [IDX_W-1:0]     best_idx;
	logic [ARRIVAL_W-1:0] best_arr;
	logic [CNT_W-1:0]     run_cnt;
	logic [ENTRIES-1:0]   done_mask;
	logic [IDX_W-1:0]     emit_idx;
	logic [ENTRIES-1:0]   cmask_rest;
	logic [DATA_BITS-1:0] emit_sum;
	logic [LAT_W-1:0]     lat_eff;
	logic [UNITS_W-1:0]   units_eff;
	logic                 start_ok;
	logic                 do_issue;
	logic                 do_emit;

	always_comb begin
		logic [SUM_W-1:0] sum;
		free_found = 1'b0;
		free_idx   = '0;
		for (int s = ENTRIES; s >= 1; s--) begin
			sum = {1'b0, ptr_q} + SUM_W'(s);
			if (sum >= SUM_W'(ENTRIES)) begin
				sum = sum - SUM_W'(ENTRIES);
			end
			if (!busy_q[sum[IDX_W-1:0]]) begin
				free_found = 1'b1;
				free_idx   = sum[IDX_W-1:0];
			end
		end
	end

	always_comb begin
		best_found = 1'b0;
		best_idx   = '0;
		best_arr   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (busy_q[i] && !run_q[i] && btag_q[i] == '0 && otag_q[i] == '0) begin
				if (!best_found || arr_q[i] < best_arr) begin
					best_found = 1'b1;
					best_idx   = IDX_W'(i);
					best_arr   = arr_q[i];
				end
			end
		end
	end

	always_comb begin
		run_cnt   = '0;
		done_mask = '0;
		emit_idx  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			run_cnt      = run_cnt + CNT_W'(run_q[i]);
			done_mask[i] = run_q[i] && (tick_q[i] == LAT_W'(1));
		end
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (cmask_q[i]) begin
				emit_idx = IDX_W'(i);
			end
		end
		cmask_rest           = cmask_q;
		cmask_rest[emit_idx] = 1'b0;
	end

	assign emit_sum  = bval_q[emit_idx] + oval_q[emit_idx];
	assign lat_eff   = (lat_q == '0) ? LAT_W'(1) : lat_q;
	assign units_eff = (units_q > MAX_UNITS) ? MAX_UNITS : units_q;
	assign start_ok  = best_found && (8'(run_cnt) < 8'(units_eff));

	assign do_issue = (state_q == S_IDLE) && cq_valid && (cq_op == OP_ISSUE) && res_ready;
	assign do_emit  = (state_q == S_EMIT) && (cmask_q != '0) && res_ready;
	assign cq_pop   = (state_q == S_IDLE) && cq_valid && ((cq_op != OP_ISSUE) || res_ready);
	assign res_push = do_issue || do_emit;

	always_comb begin
		res = '0;
		if (state_q == S_EMIT) begin
			res.kind     = KIND_DONE;
			res.accepted = 1'b1;
			res.entry    = ENTRY_W'(emit_idx);
			res.address  = ADDR_W'(emit_sum);
			res.last     = (cmask_rest == '0);
		end else begin
			res.kind     = KIND_ISSUE;
			res.accepted = free_found;
			res.entry    = free_found ? ENTRY_W'(free_idx) : '0;
			res.last     = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= '0;
			run_q   <= '0;
			cmask_q <= '0;
			btag_q  <= '{default: '0};
			otag_q  <= '{default: '0};
			ptr_q   <= IDX_W'(ENTRIES - 1);
			lat_q   <= LATENCY_RST;
			units_q <= UNITS_RST;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_LOAD_LATENCY: lat_q   <= cfg_data[LAT_W-1:0];
					REG_LOAD_UNITS:   units_q <= cfg_data[UNITS_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (cq_valid) begin
						case (cq_op)
							OP_ISSUE: begin
								if (res_ready && free_found) begin
									ptr_q            <= free_idx;
									busy_q[free_idx] <= 1'b1;
									run_q[free_idx]  <= 1'b0;
									btag_q[free_idx] <= cq_tag_a;
									otag_q[free_idx] <= cq_tag_b;
								end
							end
							OP_BCAST: begin
								for (int i = 0; i < ENTRIES; i++) begin
									if (busy_q[i] && cq_tag_a != '0) begin
										if (btag_q[i] == cq_tag_a) btag_q[i] <= '0;
										if (otag_q[i] == cq_tag_a) otag_q[i] <= '0;
									end
								end
							end
							OP_TICK: begin
								for (int i = 0; i < ENTRIES; i++) begin
									if (run_q[i] && tick_q[i] == '0) begin
										busy_q[i] <= 1'b0;
										run_q[i]  <= 1'b0;
										btag_q[i] <= '0;
										otag_q[i] <= '0;
									end
								end
								cmask_q <= done_mask;
								state_q <= S_EMIT;
							end
							default: ;
						endcase
					end
				end
				S_EMIT: begin
					if (cmask_q == '0) begin
						state_q <= S_START;
					end else if (res_ready) begin
						cmask_q <= cmask_rest;
					end
				end
				S_START: begin
					if (start_ok) begin
						run_q[best_idx] <= 1'b1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cq_valid && cq_op == OP_ISSUE && res_ready && free_found) begin
					bval_q[free_idx] <= (cq_tag_a != '0) ? '0 : cq_val_a;
					oval_q[free_idx] <= (cq_tag_b != '0) ? '0 : cq_val_b;
					arr_q[free_idx]  <= cq_arrival;
				end
				if (cq_valid && cq_op == OP_BCAST && cq_tag_a != '0) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (busy_q[i] && btag_q[i] == cq_tag_a) bval_q[i] <= cq_val_a;
						if (busy_q[i] && otag_q[i] == cq_tag_a) oval_q[i] <= cq_val_a;
					end
				end
				if (cq_valid && cq_op == OP_TICK) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (run_q[i] && tick_q[i] != '0) tick_q[i] <= tick_q[i] - 1'b1;
					end
				end
			end
			S_START: begin
				if (start_ok) tick_q[best_idx] <= lat_eff;
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/lrb_resq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load reservation buffer result queue
// Holds finished results until the receiver pops them, so the back end can
// keep working while the receiver stalls.
// ----------------------------------------------------------------------------
module lrb_resq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_push,
	output logic          res_ready,
	input  lrb_pkg::res_t res,
	input  logic          pop,
	output logic          empty,
	output lrb_pkg::res_t head
);
	import lrb_pkg::*;

	res_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               enq;
	logic               deq;

	assign res_ready = (cnt_q != Q_CNT_W'(Q_DEPTH));
	assign empty     = (cnt_q == '0);
	assign enq       = res_push && res_ready;
	assign deq       = pop && !empty;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (deq) begin
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			mem_q[wr_q] <= res;
		end
	end

endmodule

FILE: rtl/core/load_reservation_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load reservation buffer core
// Load buffer of an out-of-order core: issue, result bus capture and
// countdown of executing loads with oldest-first start.
//
// Input queue: push a request while full is low; cmd selects issue, bus
// broadcast or clock tick, and unknown commands are dropped. Result queue:
// while empty is low the oldest result is on kind, accepted, entry, address
// and last; pop takes it. Configuration: cfg_valid/cfg_ready with cfg_index
// and cfg_data, always ready, to be written only while the block is idle.
// A request waits in a two-deep command queue and then goes to the back-end
// sequencer; a tick there passes an emit state, with completions emitted one
// per cycle while the result queue has room, and a start state, with loads
// started one per cycle. Empty goes low in the cycle after a result push.
// A stalled receiver fills the two-deep result queue, which holds the
// sequencer, which in turn fills the command queue and raises full.
// Reset clears all entries, both queues and sets the configuration registers
// to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module load_reservation_buffer_core #(
	parameter int ENTRIES   = lrb_pkg::ENTRIES_DEF,
	parameter int TAG_BITS  = lrb_pkg::TAG_BITS_DEF,
	parameter int DATA_BITS = lrb_pkg::DATA_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [lrb_pkg::CMD_W-1:0]       cmd,
	input  logic [TAG_BITS-1:0]             base_tag,
	input  logic [DATA_BITS-1:0]            base_value,
	input  logic [TAG_BITS-1:0]             offset_tag,
	input  logic [DATA_BITS-1:0]            offset_value,
	input  logic [lrb_pkg::ARRIVAL_W-1:0]   arrival,
	input  logic [TAG_BITS-1:0]             bus_tag,
	input  logic [DATA_BITS-1:0]            bus_value,
	output logic                            empty,
	input  logic                            pop,
	output logic                            kind,
	output logic                            accepted,
	output logic [lrb_pkg::ENTRY_W-1:0]     entry,
	output logic [lrb_pkg::ADDR_W-1:0]      address,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lrb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lrb_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import lrb_pkg::*;

	logic                 cq_valid;
	logic                 cq_pop;
	op_t                  cq_op;
	logic [TAG_BITS-1:0]  cq_tag_a;
	logic [DATA_BITS-1:0] cq_val_a;
	logic [TAG_BITS-1:0]  cq_tag_b;
	logic [DATA_BITS-1:0] cq_val_b;
	logic [ARRIVAL_W-1:0] cq_arrival;
	logic                 res_push;
	logic                 res_ready;
	res_t                 res;
	res_t                 head;

	assign cfg_ready = 1'b1;

	lrb_front #(
		.TAG_BITS  (TAG_BITS),
		.DATA_BITS (DATA_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.base_tag     (base_tag),
		.base_value   (base_value),
		.offset_tag   (offset_tag),
		.offset_value (offset_value),
		.arrival      (arrival),
		.bus_tag      (bus_tag),
		.bus_value    (bus_value),
		.cq_valid     (cq_valid),
		.cq_pop       (cq_pop),
		.cq_op        (cq_op),
		.cq_tag_a     (cq_tag_a),
		.cq_val_a     (cq_val_a),
		.cq_tag_b     (cq_tag_b),
		.cq_val_b     (cq_val_b),
		.cq_arrival   (cq_arrival)
	);

	lrb_back #(
		.ENTRIES   (ENTRIES),
		.TAG_BITS  (TAG_BITS),
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cq_valid   (cq_valid),
		.cq_pop     (cq_pop),
		.cq_op      (cq_op),
		.cq_tag_a   (cq_tag_a),
		.cq_val_a   (cq_val_a),
		.cq_tag_b   (cq_tag_b),
		.cq_val_b   (cq_val_b),
		.cq_arrival (cq_arrival),
		.res_push   (res_push),
		.res_ready  (res_ready),
		.res        (res)
	);

	lrb_resq u_resq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res_ready (res_ready),
		.res       (res),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	assign kind     = head.kind;
	assign accepted = head.accepted;
	assign entry    = head.entry;
	assign address  = head.address;
	assign last     = head.last;

	a_issue_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ISSUE) |-> last)
		else $error("issue response not marked last");

	a_issue_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ISSUE) |-> (address == '0))
		else $error("issue response carries an address");

	a_done_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_DONE) |-> accepted)
		else $error("completion not marked accepted");

	a_full_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ISSUE && !accepted) |-> (entry == '0))
		else $error("full response names an entry");

endmodule

FILE: tb/tb_load_reservation_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load reservation buffer core testbench
// Drives issue, result bus and tick requests through the input queue while
// both sides idle at random, and checks every result against a cycle-free
// model of the buffer that tracks entries, operand capture, countdown and
// oldest-first start. A short table of directed requests comes first, then
// random phases under several latency and unit settings.
// ----------------------------------------------------------------------------
module tb_load_reservation_buffer_core;

	import lrb_pkg::*;

	localparam int N_SLOTS     = ENTRIES_DEF;
	localparam int TAG_W       = TAG_BITS_DEF;
	localparam int DATA_W      = DATA_BITS_DEF;
	localparam int PHASE_ITEMS = 19;
	localparam int SETTLE      = 24;
	localparam int LIMIT       = 3000;
	localparam int N_DIRECTED  = 21;
	localparam int N_PHASES    = 7;

	localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [TAG_W-1:0]     base_tag;
		logic [DATA_W-1:0]    base_value;
		logic [TAG_W-1:0]     offset_tag;
		logic [DATA_W-1:0]    offset_value;
		logic [ARRIVAL_W-1:0] arrival;
		logic [TAG_W-1:0]     bus_tag;
		logic [DATA_W-1:0]    bus_value;
	} req_t;

	typedef struct packed {
		req_t item;
		logic typed;
		res_t want;
	} row_t;

	logic                  clk;
	logic                  arst_n       = 1'b0;
	logic                  push         = 1'b0;
	logic                  full;
	logic [CMD_W-1:0]      cmd          = '0;
	logic [TAG_W-1:0]      base_tag     = '0;
	logic [DATA_W-1:0]     base_value   = '0;
	logic [TAG_W-1:0]      offset_tag   = '0;
	logic [DATA_W-1:0]     offset_value = '0;
	logic [ARRIVAL_W-1:0]  arrival      = '0;
	logic [TAG_W-1:0]      bus_tag      = '0;
	logic [DATA_W-1:0]     bus_value    = '0;
	logic                  empty;
	logic                  pop          = 1'b0;
	logic                  kind;
	logic                  accepted;
	logic [ENTRY_W-1:0]    entry;
	logic [ADDR_W-1:0]     address;
	logic                  last;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// buffer model state
	logic                 slot_busy[N_SLOTS];
	logic [TAG_W-1:0]     base_wait[N_SLOTS];
	logic [DATA_W-1:0]    base_val[N_SLOTS];
	logic [TAG_W-1:0]     off_wait[N_SLOTS];
	logic [DATA_W-1:0]    off_val[N_SLOTS];
	int                   countdown[N_SLOTS];
	logic [ARRIVAL_W-1:0] stamp[N_SLOTS];
	int                   rover;
	logic [LAT_W-1:0]     cfg_latency;
	logic [UNITS_W-1:0]   cfg_units;

	res_t                 fresh_results[$];
	res_t                 due_results[$];
	row_t                 dir_tab[N_DIRECTED];
	logic [ARRIVAL_W-1:0] arrival_next = '0;
	bit                   send_calm    = 1'b0;
	bit                   pop_calm     = 1'b0;
	int                   errors       = 0;
	int                   quiet        = 0;

	logic [LAT_W-1:0]      phase_lat[N_PHASES]   = '{4'd1, 4'd15, 4'd0, 4'd5, 4'd3, 4'd9, 4'd2};
	logic [CFG_DATA_W-1:0] phase_units[N_PHASES] = '{4'd4, 4'd1, 4'd15, 4'd8, 4'd3, 4'd2, 4'd6};

	load_reservation_buffer_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .cmd(cmd),
		.base_tag(base_tag), .base_value(base_value), .offset_tag(offset_tag),
		.offset_value(offset_value), .arrival(arrival), .bus_tag(bus_tag),
		.bus_value(bus_value), .empty(empty), .pop(pop), .kind(kind),
		.accepted(accepted), .entry(entry), .address(address), .last(last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic clear_slot(input int i);
		slot_busy[i] = 1'b0;
		base_wait[i] = '0;
		base_val[i]  = '0;
		off_wait[i]  = '0;
		off_val[i]   = '0;
		countdown[i] = -1;
		stamp[i]     = '0;
	endtask

	task automatic buffer_reset();
		for (int i = 0; i < N_SLOTS; i++)
			clear_slot(i);
		rover       = N_SLOTS - 1;
		cfg_latency = LATENCY_RST;
		cfg_units   = UNITS_RST;
	endtask

	// results of one request land in fresh_results
	task automatic buffer_advance(input req_t it);
		res_t r;
		int found, c, units, lat, running, best;
		fresh_results.delete();
		r = '0;
		if (it.cmd == CMD_ISSUE) begin
			found = -1;
			for (int s = 1; s <= N_SLOTS; s++) begin
				c = (rover + s) % N_SLOTS;
				if (found < 0 && !slot_busy[c])
					found = c;
			end
			r.kind = KIND_ISSUE;
			r.last = 1'b1;
			if (found >= 0) begin
				rover            = found;
				slot_busy[found] = 1'b1;
				base_wait[found] = it.base_tag;
				base_val[found]  = (it.base_tag != 0) ? '0 : it.base_value;
				off_wait[found]  = it.offset_tag;
				off_val[found]   = (it.offset_tag != 0) ? '0 : it.offset_value;
				countdown[found] = -1;
				stamp[found]     = it.arrival;
				r.accepted       = 1'b1;
				r.entry          = ENTRY_W'(found);
			end
			fresh_results.push_back(r);
		end else if (it.cmd == CMD_BCAST) begin
			if (it.bus_tag != 0) begin
				for (int i = 0; i < N_SLOTS; i++) begin
					if (slot_busy[i] && base_wait[i] == it.bus_tag) begin
						base_val[i]  = it.bus_value;
						base_wait[i] = '0;
					end
					if (slot_busy[i] && off_wait[i] == it.bus_tag) begin
						off_val[i]  = it.bus_value;
						off_wait[i] = '0;
					end
				end
			end
		end else if (it.cmd == CMD_TICK) begin
			units   = (cfg_units > MAX_UNITS) ? int'(MAX_UNITS) : int'(cfg_units);
			lat     = (cfg_latency == 0) ? 1 : int'(cfg_latency);
			running = 0;
			for (int i = 0; i < N_SLOTS; i++) begin
				if (slot_busy[i] && countdown[i] >= 0) begin
					countdown[i]--;
					if (countdown[i] == 0) begin
						r.kind     = KIND_DONE;
						r.accepted = 1'b1;
						r.entry    = ENTRY_W'(i);
						r.address  = base_val[i] + off_val[i];
						r.last     = 1'b0;
						fresh_results.push_back(r);
					end
					if (countdown[i] < 0)
						clear_slot(i);
				end
			end
			for (int i = 0; i < N_SLOTS; i++)
				if (countdown[i] >= 0)
					running++;
			for (int k = 0; k < units - running; k++) begin
				best = -1;
				for (int i = 0; i < N_SLOTS; i++) begin
					if (slot_busy[i] && countdown[i] < 0 && base_wait[i] == 0 &&
					    off_wait[i] == 0 && (best < 0 || stamp[i] < stamp[best]))
						best = i;
				end
				if (best >= 0)
					countdown[best] = lat;
			end
			if (fresh_results.size() > 0)
				fresh_results[fresh_results.size() - 1].last = 1'b1;
		end
	endtask

	function automatic row_t stim(input logic [CMD_W-1:0] c, input logic [TAG_W-1:0] bt,
	                              input logic [DATA_W-1:0] bv, input logic [TAG_W-1:0] ot,
	                              input logic [DATA_W-1:0] ov, input logic [ARRIVAL_W-1:0] arr,
	                              input logic [TAG_W-1:0] tg, input logic [DATA_W-1:0] tv);
		row_t r;
		r = '0;
		r.item = '{cmd: c, base_tag: bt, base_value: bv, offset_tag: ot,
		           offset_value: ov, arrival: arr, bus_tag: tg, bus_value: tv};
		return r;
	endfunction

	function automatic row_t grant(input row_t r, input logic acc, input logic [ENTRY_W-1:0] ent);
		row_t g;
		g                = r;
		g.typed          = 1'b1;
		g.want.kind      = KIND_ISSUE;
		g.want.accepted  = acc;
		g.want.entry     = ent;
		g.want.address   = '0;
		g.want.last      = 1'b1;
		return g;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return {1'b1, {(DATA_W - 1){1'b0}}};
			default: return DATA_W'($urandom);
		endcase
	endfunction

	function automatic req_t rand_item();
		req_t it;
		logic [TAG_W-1:0] waiting[$];
		int r;
		r = $urandom_range(0, 99);
		if (r < 36)
			it.cmd = CMD_ISSUE;
		else if (r < 56)
			it.cmd = CMD_BCAST;
		else if (r < 96)
			it.cmd = CMD_TICK;
		else
			it.cmd = CMD_NONE;
		it.base_tag     = ($urandom_range(0, 2) == 0) ? TAG_W'($urandom_range(1, 15)) : '0;
		it.offset_tag   = ($urandom_range(0, 2) == 0) ? TAG_W'($urandom_range(1, 15)) : '0;
		it.base_value   = pick_word();
		it.offset_value = pick_word();
		if ($urandom_range(0, 9) == 0) begin
			it.arrival = ARRIVAL_W'($urandom);
		end else begin
			arrival_next = arrival_next + ARRIVAL_W'($urandom_range(0, 2));
			it.arrival   = arrival_next;
		end
		for (int i = 0; i < N_SLOTS; i++) begin
			if (slot_busy[i] && base_wait[i] != 0)
				waiting.push_back(base_wait[i]);
			if (slot_busy[i] && off_wait[i] != 0)
				waiting.push_back(off_wait[i]);
		end
		if (waiting.size() > 0 && $urandom_range(0, 4) != 0)
			it.bus_tag = waiting[$urandom_range(0, waiting.size() - 1)];
		else
			it.bus_tag = TAG_W'($urandom_range(0, 15));
		it.bus_value = pick_word();
		return it;
	endfunction

	task automatic send_req(input req_t it, input logic typed, input res_t want);
		int g;
		g = send_calm ? 0 : pick_gap();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		push         <= 1'b1;
		cmd          <= it.cmd;
		base_tag     <= it.base_tag;
		base_value   <= it.base_value;
		offset_tag   <= it.offset_tag;
		offset_value <= it.offset_value;
		arrival      <= it.arrival;
		bus_tag      <= it.bus_tag;
		bus_value    <= it.bus_value;
		@(posedge clk);
		while (full)
			@(posedge clk);
		buffer_advance(it);
		if (typed) begin
			due_results.push_back(want);
		end else begin
			foreach (fresh_results[k])
				due_results.push_back(fresh_results[k]);
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] lat_data,
	                        input logic [CFG_DATA_W-1:0] units_data);
		cfg_valid <= 1'b1;
		cfg_index <= REG_LOAD_LATENCY;
		cfg_data  <= lat_data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_latency = lat_data[LAT_W-1:0];
		cfg_index <= REG_LOAD_UNITS;
		cfg_data  <= units_data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_units = units_data[UNITS_W-1:0];
		cfg_valid <= 1'b0;
	endtask

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic match(input string name, input logic [ADDR_W-1:0] got,
	                     input logic [ADDR_W-1:0] want);
		if (got !== want)
			report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	task automatic check_result();
		res_t want;
		if (due_results.size() == 0) begin
			report($sformatf("result with none due: kind %0b entry %0d address %08h",
			                 kind, entry, address));
			return;
		end
		want = due_results.pop_front();
		match("kind", ADDR_W'(kind), ADDR_W'(want.kind));
		match("accepted", ADDR_W'(accepted), ADDR_W'(want.accepted));
		match("entry", ADDR_W'(entry), ADDR_W'(want.entry));
		match("address", address, want.address);
		match("last", ADDR_W'(last), ADDR_W'(want.last));
	endtask

	initial begin : results_side
		int g;
		wait (arst_n === 1'b1);
		forever begin
			g = pop_calm ? 0 : pick_gap();
			if (g > 0) begin
				pop <= 1'b0;
				repeat (g) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
			check_result();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= LIMIT) begin
				$display("tb_load_reservation_buffer_core failed");
				$finish;
			end
		end
	end

	initial begin : requests_side
		req_t it;
		int counted;
		dir_tab = '{
			grant(stim(CMD_ISSUE, 4'd0, 32'hFFFF_FFFF, 4'd0, 32'd1, 16'hFFFF, 4'd0, 32'd0),
			      1'b1, 2'd0),
			grant(stim(CMD_ISSUE, 4'd15, 32'h1234_5678, 4'd0, 32'd0, 16'h0000, 4'd0, 32'd0),
			      1'b1, 2'd1),
			grant(stim(CMD_ISSUE, 4'd0, 32'h8000_0000, 4'd15, 32'hDEAD_BEEF, 16'd5, 4'd0, 32'd0),
			      1'b1, 2'd2),
			grant(stim(CMD_ISSUE, 4'd3, 32'hFFFF_FFFF, 4'd3, 32'hFFFF_FFFF, 16'd1, 4'd0, 32'd0),
			      1'b1, 2'd3),
			grant(stim(CMD_ISSUE, 4'd0, 32'd7, 4'd0, 32'd9, 16'd2, 4'd0, 32'd0), 1'b0, 2'd0),
			stim(CMD_BCAST, 4'd3, 32'd0, 4'd3, 32'd0, 16'd0, 4'd0, 32'h5555_5555),
			stim(CMD_NONE, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd3, 32'hAAAA_AAAA),
			stim(CMD_BCAST, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd15, 32'hFFFF_FFFF),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0),
			stim(CMD_ISSUE, 4'd0, 32'd0, 4'd0, 32'd0, 16'd1, 4'd0, 32'd0),
			stim(CMD_ISSUE, 4'd0, 32'hFFFF_FFFF, 4'd0, 32'hFFFF_FFFF, 16'd1, 4'd0, 32'd0),
			stim(CMD_BCAST, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd3, 32'h0000_FFFF),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0),
			stim(CMD_TICK, 4'd0, 32'd0, 4'd0, 32'd0, 16'd0, 4'd0, 32'd0)
		};
		buffer_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_tab[k])
			send_req(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].want);
		settle();
		for (int p = 0; p < N_PHASES; p++) begin
			set_regs(phase_lat[p], phase_units[p]);
			send_calm = ($urandom_range(0, 3) == 0);
			pop_calm  = ($urandom_range(0, 3) == 0);
			counted   = 0;
			while (counted < PHASE_ITEMS) begin
				it = rand_item();
				if (it.cmd != CMD_NONE)
					counted++;
				send_req(it, 1'b0, '0);
			end
			settle();
		end
		if (errors == 0)
			$display("tb_load_reservation_buffer_core passed");
		else
			$display("tb_load_reservation_buffer_core failed");
		$finish;
	end

endmodule
